FILE: hdl/lrgd_pkg.sv
// ----------------------------------------------------------------------------
// lrgd_pkg: shared definitions for the gradient descent regression block
// Widths of the fixed-point fields, reset values of the control registers,
// controller command bundle and the fixed-point helper functions.
// ----------------------------------------------------------------------------
package lrgd_pkg;

    // Field and arithmetic widths
    localparam int DATA_W      = 32;   // Q16.16 word
    localparam int ACC_W       = 64;   // prediction and gradient sums
    localparam int FEAT_FIELDS = 8;    // feature fields on the input port
    localparam int FC_W        = 4;    // feature count and coefficient index
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int DIVD_W      = 65;   // 2 * |gradient sum|
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 33;
    localparam int MUL_W       = 65;
    localparam int STEP_W      = 34;

    localparam logic [STEP_W-1:0] STEP_MAX = 34'h2_0000_0000;

    // Default parameter values
    localparam int DEF_MAX_SAMPLES  = 1024;
    localparam int DEF_MAX_FEATURES = 8;

    // Reset values of the control registers
    localparam logic [CFG_W-1:0] LR_RESET    = 32'd429;
    localparam logic [CFG_W-1:0] EPOCH_RESET = 32'd1000;
    localparam logic [FC_W-1:0]  FC_RESET    = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE = 2'd0,
        CFG_EPOCH_LIMIT   = 2'd1,
        CFG_FEATURE_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_COEF_X,
        MUL_RES_X,
        MUL_LR_LO,
        MUL_LR_HI
    } t_mul_op;

    typedef logic [FEAT_FIELDS-1:0][DATA_W-1:0] t_row;

    // Controller to datapath commands
    typedef struct packed {
        logic    ld_we;
        logic    coef_clr;
        logic    gsum_clr;
        logic    acc_init;
        logic    acc_add;
        logic    res_we;
        logic    gsum_add_res;
        logic    gsum_add_prod;
        logic    div_start;
        logic    lo_save;
        logic    coef_upd;
        logic    out_load;
        t_mul_op mul_op;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } t_stat;

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(0) - DATA_W'(v) : DATA_W'(v);
    endfunction

    function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(0) - ACC_W'(v) : ACC_W'(v);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: hdl/lrgd_ram.sv
// ----------------------------------------------------------------------------
// lrgd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lrgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/lrgd_div.sv
// ----------------------------------------------------------------------------
// lrgd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module lrgd_div #(
    parameter int DIVIDEND_W = 65,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dsr;
    logic [DIVISOR_W:0]    w_trial;
    logic                  w_ge;

    // Trial subtraction
    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_BITS'(DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
            r_rem <= w_ge ? DIVISOR_W'(w_trial - {1'b0, r_dsr}) : w_trial[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: hdl/lrgd_dp.sv
// ----------------------------------------------------------------------------
// lrgd_dp: training datapath
// Sample stores, coefficients, gradient sums, the shared multiplier, the
// divider and the saturating coefficient update.
// ----------------------------------------------------------------------------
module lrgd_dp import lrgd_pkg::*; #(
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  t_cmd                                     i_cmd,
    output t_stat                                    o_stat,
    input  logic [$clog2(MAX_FEATURES+1)-1:0]        i_cidx,
    input  logic [(MAX_FEATURES>1 ? $clog2(MAX_FEATURES) : 1)-1:0] i_lane,
    input  logic [$clog2(MAX_SAMPLES)-1:0]           i_wr_addr,
    input  logic [$clog2(MAX_SAMPLES)-1:0]           i_rd_addr,
    input  logic [$clog2(MAX_SAMPLES+1)-1:0]         i_n,
    input  t_row                                     i_row,
    input  logic [DATA_W-1:0]                        i_target,
    input  logic [CFG_W-1:0]                         i_lr,
    output logic signed [DATA_W-1:0]                 o_coefficient
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int NCOEF = MAX_FEATURES + 1;

    logic signed [DATA_W-1:0] r_coef [NCOEF];
    logic signed [ACC_W-1:0]  r_gsum [NCOEF];
    logic signed [ACC_W-1:0]  r_acc;
    logic [MUL_W-1:0]         r_mul;
    logic                     r_neg;
    logic [DATA_W-1:0]        r_lo;
    logic signed [DATA_W-1:0] r_out;

    logic [DATA_W-1:0]        w_x [MAX_FEATURES];
    logic [DATA_W-1:0]        w_tgt_raw;
    logic [DATA_W-1:0]        w_res_raw;
    logic signed [DATA_W-1:0] w_tgt;
    logic signed [DATA_W-1:0] w_res;
    logic signed [DATA_W-1:0] w_x_sel;
    logic signed [DATA_W-1:0] w_coef_sel;
    logic signed [ACC_W-1:0]  w_gsum_sel;
    logic signed [DATA_W-1:0] w_res_val;
    logic [MUL_A_W-1:0]       w_a;
    logic [MUL_B_W-1:0]       w_b;
    logic                     w_neg;
    logic signed [ACC_W-1:0]  w_term;
    logic [MUL_W:0]           w_step_full;
    logic [STEP_W-1:0]        w_step;
    logic signed [ACC_W-1:0]  w_upd;
    logic signed [DATA_W-1:0] w_new;
    logic [DIVD_W-1:0]        w_quo;

    // Feature stores, one lane per feature
    for (genvar g = 0; g < MAX_FEATURES; g++) begin : g_lane
        lrgd_ram #(
            .WIDTH (DATA_W),
            .DEPTH (MAX_SAMPLES)
        ) u_feat (
            .i_clk   (i_clk),
            .i_we    (i_cmd.ld_we),
            .i_waddr (i_wr_addr),
            .i_wdata (i_row[g]),
            .i_raddr (i_rd_addr),
            .o_rdata (w_x[g])
        );
    end

    lrgd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SAMPLES)
    ) u_target (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_we),
        .i_waddr (i_wr_addr),
        .i_wdata (i_target),
        .i_raddr (i_rd_addr),
        .o_rdata (w_tgt_raw)
    );

    lrgd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SAMPLES)
    ) u_resid (
        .i_clk   (i_clk),
        .i_we    (i_cmd.res_we),
        .i_waddr (i_rd_addr),
        .i_wdata (w_res_val),
        .i_raddr (i_rd_addr),
        .o_rdata (w_res_raw)
    );

    assign w_tgt      = w_tgt_raw;
    assign w_res      = w_res_raw;
    assign w_x_sel    = w_x[i_lane];
    assign w_coef_sel = r_coef[i_cidx];
    assign w_gsum_sel = r_gsum[i_cidx];

    // Multiplier operand selection on magnitudes
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_neg = 1'b0;
        unique case (i_cmd.mul_op)
            MUL_COEF_X: begin
                w_a   = mag32(w_coef_sel);
                w_b   = {1'b0, mag32(w_x_sel)};
                w_neg = w_coef_sel[DATA_W-1] ^ w_x_sel[DATA_W-1];
            end
            MUL_RES_X: begin
                w_a   = mag32(w_res);
                w_b   = {1'b0, mag32(w_x_sel)};
                w_neg = w_res[DATA_W-1] ^ w_x_sel[DATA_W-1];
            end
            MUL_LR_LO: begin
                w_a = i_lr;
                w_b = {1'b0, w_quo[DATA_W-1:0]};
            end
            MUL_LR_HI: begin
                w_a = i_lr;
                w_b = w_quo[DIVD_W-1:DATA_W];
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    // Registered product
    always_ff @(posedge i_clk) begin
        r_mul <= MUL_W'(w_a) * MUL_W'(w_b);
        r_neg <= w_neg;
    end

    // Q16.16 product, truncated toward zero
    assign w_term = r_neg ? -ACC_W'(r_mul[63:16]) : ACC_W'(r_mul[63:16]);

    // Prediction accumulator and residual
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_init) begin
            r_acc <= ACC_W'(r_coef[0]);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign w_res_val = sat32(r_acc - ACC_W'(w_tgt));

    // Gradient sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.gsum_clr) begin
            for (int i = 0; i < NCOEF; i++) begin
                r_gsum[i] <= '0;
            end
        end else if (i_cmd.gsum_add_res) begin
            r_gsum[0] <= r_gsum[0] + ACC_W'(w_res);
        end else if (i_cmd.gsum_add_prod) begin
            r_gsum[i_cidx] <= w_gsum_sel + w_term;
        end
    end

    // Gradient magnitude divided by the sample count
    lrgd_div #(
        .DIVIDEND_W (DIVD_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({mag64(w_gsum_sel), 1'b0}),
        .i_divisor  (i_n),
        .o_done     (o_stat.div_done),
        .o_quotient (w_quo)
    );

    // Step = lr * gradient / 2^32, clamped, then saturating update
    always_ff @(posedge i_clk) begin
        if (i_cmd.lo_save) begin
            r_lo <= r_mul[63:32];
        end
    end

    assign w_step_full = {1'b0, r_mul} + (MUL_W+1)'(r_lo);
    assign w_step      = (w_step_full > (MUL_W+1)'(STEP_MAX)) ? STEP_MAX
                                                             : w_step_full[STEP_W-1:0];
    assign w_upd       = w_gsum_sel[ACC_W-1] ? ACC_W'(w_coef_sel) + ACC_W'(w_step)
                                             : ACC_W'(w_coef_sel) - ACC_W'(w_step);
    assign w_new       = sat32(w_upd);

    // Coefficients
    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_clr) begin
            for (int i = 0; i < NCOEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cmd.coef_upd) begin
            r_coef[i_cidx] <= w_new;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= w_coef_sel;
        end
    end

    assign o_coefficient = r_out;

endmodule

FILE: hdl/lrgd_ctrl.sv
// ----------------------------------------------------------------------------
// lrgd_ctrl: training sequencer
// Loads rows, steps through the residual, gradient and update phases of
// every epoch, then transfers the coefficients out.
// ----------------------------------------------------------------------------
module lrgd_ctrl import lrgd_pkg::*; #(
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic                                     i_last_sample,
    output logic                                     o_stall,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic [FC_W-1:0]                          o_coef_index,
    output logic                                     o_last_coef,
    input  logic [CFG_W-1:0]                         i_epoch_limit,
    input  logic [FC_W-1:0]                          i_feats,
    output t_cmd                                     o_cmd,
    input  t_stat                                    i_stat,
    output logic [$clog2(MAX_FEATURES+1)-1:0]        o_cidx,
    output logic [(MAX_FEATURES>1 ? $clog2(MAX_FEATURES) : 1)-1:0] o_lane,
    output logic [$clog2(MAX_SAMPLES)-1:0]           o_wr_addr,
    output logic [$clog2(MAX_SAMPLES)-1:0]           o_rd_addr,
    output logic [$clog2(MAX_SAMPLES+1)-1:0]         o_n
);

    localparam int AW     = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W  = $clog2(MAX_FEATURES + 1);
    localparam int LANE_W = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_EPOCH,
        S_A_RD,
        S_A_MUL,
        S_A_ACC,
        S_A_RES,
        S_B_RD,
        S_B_SUM,
        S_B_MUL,
        S_B_ACC,
        S_C_DIV,
        S_C_WAIT,
        S_C_MLO,
        S_C_MHI,
        S_C_UPD,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_rows;
    logic [CNT_W-1:0] r_n;
    logic [AW-1:0]    r_row;
    logic [FC_W-1:0]  r_k;
    logic [CFG_W-1:0] r_epoch;
    logic             r_out_valid;
    logic [FC_W-1:0]  r_out_idx;
    logic             r_out_last;

    logic             w_full;
    logic             w_slot;
    logic             w_last_row;
    logic             w_last_feat;
    logic [FC_W-1:0]  w_k_next;

    assign w_full      = r_rows == CNT_W'(MAX_SAMPLES);
    assign w_slot      = !r_out_valid || !i_stall;
    assign w_last_row  = CNT_W'(r_row) == r_n - CNT_W'(1);
    assign w_k_next    = r_k + FC_W'(1);
    assign w_last_feat = w_k_next == i_feats;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_rows      <= '0;
            r_n         <= '0;
            r_row       <= '0;
            r_k         <= '0;
            r_epoch     <= '0;
            r_out_valid <= 1'b0;
            r_out_idx   <= '0;
            r_out_last  <= 1'b0;
        end else begin
            // drop the result once transferred, unless a new one follows
            if (r_out_valid && !i_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        if (i_last_sample) begin
                            r_n     <= w_full ? r_rows : r_rows + CNT_W'(1);
                            r_rows  <= '0;
                            r_epoch <= '0;
                            r_state <= S_EPOCH;
                        end else if (!w_full) begin
                            r_rows <= r_rows + CNT_W'(1);
                        end
                    end
                end
                S_EPOCH: begin
                    r_row <= '0;
                    r_k   <= '0;
                    r_state <= (r_epoch == i_epoch_limit) ? S_EMIT : S_A_RD;
                end
                S_A_RD: begin
                    r_k     <= '0;
                    r_state <= (i_feats == '0) ? S_A_RES : S_A_MUL;
                end
                S_A_MUL: begin
                    r_state <= S_A_ACC;
                end
                S_A_ACC: begin
                    if (w_last_feat) begin
                        r_state <= S_A_RES;
                    end else begin
                        r_k     <= w_k_next;
                        r_state <= S_A_MUL;
                    end
                end
                S_A_RES: begin
                    if (w_last_row) begin
                        r_row   <= '0;
                        r_state <= S_B_RD;
                    end else begin
                        r_row   <= r_row + AW'(1);
                        r_state <= S_A_RD;
                    end
                end
                S_B_RD: begin
                    r_k     <= '0;
                    r_state <= S_B_SUM;
                end
                S_B_SUM: begin
                    if (i_feats != '0) begin
                        r_state <= S_B_MUL;
                    end else if (w_last_row) begin
                        r_state <= S_C_DIV;
                    end else begin
                        r_row   <= r_row + AW'(1);
                        r_state <= S_B_RD;
                    end
                end
                S_B_MUL: begin
                    r_state <= S_B_ACC;
                end
                S_B_ACC: begin
                    if (!w_last_feat) begin
                        r_k     <= w_k_next;
                        r_state <= S_B_MUL;
                    end else if (w_last_row) begin
                        r_k     <= '0;
                        r_state <= S_C_DIV;
                    end else begin
                        r_row   <= r_row + AW'(1);
                        r_state <= S_B_RD;
                    end
                end
                S_C_DIV: begin
                    r_state <= S_C_WAIT;
                end
                S_C_WAIT: begin
                    if (i_stat.div_done) begin
                        r_state <= S_C_MLO;
                    end
                end
                S_C_MLO: begin
                    r_state <= S_C_MHI;
                end
                S_C_MHI: begin
                    r_state <= S_C_UPD;
                end
                S_C_UPD: begin
                    if (r_k == i_feats) begin
                        r_epoch <= r_epoch + CFG_W'(1);
                        r_state <= S_EPOCH;
                    end else begin
                        r_k     <= w_k_next;
                        r_state <= S_C_DIV;
                    end
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_k;
                        r_out_last  <= r_k == i_feats;
                        if (r_k == i_feats) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_k <= w_k_next;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.mul_op = MUL_NONE;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.ld_we    = i_valid && !w_full;
                o_cmd.coef_clr = i_valid && i_last_sample;
            end
            S_EPOCH:  o_cmd.gsum_clr      = r_epoch != i_epoch_limit;
            S_A_RD:   o_cmd.acc_init      = 1'b1;
            S_A_MUL:  o_cmd.mul_op        = MUL_COEF_X;
            S_A_ACC:  o_cmd.acc_add       = 1'b1;
            S_A_RES:  o_cmd.res_we        = 1'b1;
            S_B_RD:   o_cmd.mul_op        = MUL_NONE;
            S_B_SUM:  o_cmd.gsum_add_res  = 1'b1;
            S_B_MUL:  o_cmd.mul_op        = MUL_RES_X;
            S_B_ACC:  o_cmd.gsum_add_prod = 1'b1;
            S_C_DIV:  o_cmd.div_start     = 1'b1;
            S_C_WAIT: o_cmd.mul_op        = MUL_NONE;
            S_C_MLO:  o_cmd.mul_op        = MUL_LR_LO;
            S_C_MHI: begin
                o_cmd.lo_save = 1'b1;
                o_cmd.mul_op  = MUL_LR_HI;
            end
            S_C_UPD:  o_cmd.coef_upd      = 1'b1;
            S_EMIT:   o_cmd.out_load      = w_slot;
            default:  o_cmd.mul_op        = MUL_NONE;
        endcase
    end

    // Coefficient index is one above the feature lane in the product phases
    assign o_cidx    = (r_state == S_A_MUL || r_state == S_B_ACC) ? w_k_next[IDX_W-1:0]
                                                                 : r_k[IDX_W-1:0];
    assign o_lane    = r_k[LANE_W-1:0];
    assign o_wr_addr = r_rows[AW-1:0];
    assign o_rd_addr = r_row;
    assign o_n       = r_n;

    assign o_stall      = r_state != S_LOAD;
    assign o_valid      = r_out_valid;
    assign o_coef_index = r_out_idx;
    assign o_last_coef  = r_out_last;

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_we |-> r_rows < CNT_W'(MAX_SAMPLES))
        else $error("row written into a full store");

    a_rows_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD && r_state != S_EPOCH) |-> r_n != '0)
        else $error("training without rows");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD && r_state != S_EPOCH && r_state != S_EMIT)
            |-> CNT_W'(r_row) < r_n)
        else $error("row index beyond sample count");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> r_state == S_C_WAIT)
        else $error("divider finished outside the update phase");

endmodule

FILE: hdl/linear_regression_gradient_descent.sv
// ----------------------------------------------------------------------------
// linear_regression_gradient_descent: batch gradient descent trainer
// Stores Q16.16 training rows, trains a linear model over the configured
// number of epochs and transfers the bias and feature coefficients out.
// ----------------------------------------------------------------------------
// Rows are taken one per cycle while the block is loading; the row flagged
// last_sample starts training and the input stalls until every coefficient
// has been handed to the output register. In each epoch one shared 32x33
// multiplier serves every row and feature in both the residual and the
// gradient passes, and each of the F + 1 coefficient updates for F features
// waits on a bit-serial divider that performs the gradient scaling. The
// coefficients then leave at one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module linear_regression_gradient_descent import lrgd_pkg::*; #(
    parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
    parameter int MAX_FEATURES = DEF_MAX_FEATURES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // training rows
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_feature_0,
    input  logic signed [DATA_W-1:0] i_feature_1,
    input  logic signed [DATA_W-1:0] i_feature_2,
    input  logic signed [DATA_W-1:0] i_feature_3,
    input  logic signed [DATA_W-1:0] i_feature_4,
    input  logic signed [DATA_W-1:0] i_feature_5,
    input  logic signed [DATA_W-1:0] i_feature_6,
    input  logic signed [DATA_W-1:0] i_feature_7,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic                     i_last_sample,
    // coefficients
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [FC_W-1:0]          o_coef_index,
    output logic signed [DATA_W-1:0] o_coefficient,
    output logic                     o_last_coef
);

    localparam int AW     = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W  = $clog2(MAX_FEATURES + 1);
    localparam int LANE_W = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;

    logic [CFG_W-1:0]  r_lr;
    logic [CFG_W-1:0]  r_epoch_lim;
    logic [FC_W-1:0]   r_feat_cnt;

    logic [FC_W-1:0]   w_feats;
    t_row              w_row;
    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [IDX_W-1:0]  w_cidx;
    logic [LANE_W-1:0] w_lane;
    logic [AW-1:0]     w_wr_addr;
    logic [AW-1:0]     w_rd_addr;
    logic [CNT_W-1:0]  w_n;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr        <= LR_RESET;
            r_epoch_lim <= EPOCH_RESET;
            r_feat_cnt  <= FC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEARNING_RATE: r_lr        <= i_cfg_data;
                CFG_EPOCH_LIMIT:   r_epoch_lim <= i_cfg_data;
                CFG_FEATURE_COUNT: r_feat_cnt  <= i_cfg_data[FC_W-1:0];
                default:           r_lr        <= r_lr;
            endcase
        end
    end

    // Clamp the feature count to the lanes built
    assign w_feats = (r_feat_cnt > FC_W'(MAX_FEATURES)) ? FC_W'(MAX_FEATURES) : r_feat_cnt;

    assign w_row = {i_feature_7, i_feature_6, i_feature_5, i_feature_4,
                    i_feature_3, i_feature_2, i_feature_1, i_feature_0};

    lrgd_ctrl #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last_sample (i_last_sample),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_coef_index  (o_coef_index),
        .o_last_coef   (o_last_coef),
        .i_epoch_limit (r_epoch_lim),
        .i_feats       (w_feats),
        .o_cmd         (w_cmd),
        .i_stat        (w_stat),
        .o_cidx        (w_cidx),
        .o_lane        (w_lane),
        .o_wr_addr     (w_wr_addr),
        .o_rd_addr     (w_rd_addr),
        .o_n           (w_n)
    );

    lrgd_dp #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cidx        (w_cidx),
        .i_lane        (w_lane),
        .i_wr_addr     (w_wr_addr),
        .i_rd_addr     (w_rd_addr),
        .i_n           (w_n),
        .i_row         (w_row),
        .i_target      (i_target),
        .i_lr          (r_lr),
        .o_coefficient (o_coefficient)
    );

endmodule

FILE: verif/linear_regression_gradient_descent_tb.sv
// ----------------------------------------------------------------------------
// linear_regression_gradient_descent_tb: self-checking bench for the trainer
// Sends sets of training rows, predicts the trained coefficients with a
// bit-exact fixed-point model of batch gradient descent and compares every
// coefficient transfer against it, under several patterns of idling and stall.
// ----------------------------------------------------------------------------
module linear_regression_gradient_descent_tb;
    import lrgd_pkg::*;

    localparam int NSAMP      = DEF_MAX_SAMPLES;
    localparam int NFEAT      = DEF_MAX_FEATURES;
    localparam int IDLE_LIMIT = 600000;

    typedef struct {
        logic [FC_W-1:0]          idx;
        logic signed [DATA_W-1:0] coef;
        logic                     last;
    } t_coef_exp;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_feature_0 = '0, i_feature_1 = '0, i_feature_2 = '0;
    logic signed [DATA_W-1:0] i_feature_3 = '0, i_feature_4 = '0, i_feature_5 = '0;
    logic signed [DATA_W-1:0] i_feature_6 = '0, i_feature_7 = '0, i_target = '0;
    logic                     i_last_sample = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [FC_W-1:0]          o_coef_index;
    logic signed [DATA_W-1:0] o_coefficient;
    logic                     o_last_coef;

    // trainer shadow state
    int              rows_x [NSAMP][NFEAT];
    int              rows_y [NSAMP];
    int              resid [NSAMP];
    int              coefs [NFEAT+1];
    longint          grads [NFEAT+1];
    int unsigned     rows_held;
    int unsigned     sh_rate;
    int unsigned     sh_epochs;
    int unsigned     sh_feats;

    t_coef_exp       coef_q [$];
    int              errors = 0;
    int              idle_pct = 0;
    int              stall_pct = 0;
    int              quiet_cycles = 0;

    linear_regression_gradient_descent u_top (.*);

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(longint'(0) - v) : v;
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return int'(v);
    endfunction

    // Q16.16 product, truncated toward zero
    function automatic longint q_mul(int a, int b);
        longint unsigned m;
        m = (abs64(longint'(a)) * abs64(longint'(b))) >> 16;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic int descend(int coef, longint sum, int unsigned n);
        longint unsigned g, gh, gl, stp, lr;
        longint          d;
        lr  = longint'(sh_rate);
        g   = (abs64(sum) * 2) / longint'(n);
        gh  = g >> 32;
        gl  = g & 64'hFFFF_FFFF;
        stp = lr * gh + ((lr * gl) >> 32);
        if (stp > (64'd1 << 33)) stp = 64'd1 << 33;
        d = sum < 0 ? -longint'(stp) : longint'(stp);
        return clamp32(longint'(coef) - d);
    endfunction

    // Run every epoch over the held rows and queue the coefficients
    task automatic train_and_expect();
        int unsigned feats, n;
        longint      pred;
        t_coef_exp   e;
        feats = sh_feats > NFEAT ? NFEAT : sh_feats;
        n = rows_held;
        foreach (coefs[k]) coefs[k] = 0;
        for (int unsigned ep = 0; ep < sh_epochs; ep++) begin
            foreach (grads[k]) grads[k] = 0;
            for (int i = 0; i < n; i++) begin
                pred = coefs[0];
                for (int k = 0; k < feats; k++) pred += q_mul(coefs[k+1], rows_x[i][k]);
                resid[i] = clamp32(pred - longint'(rows_y[i]));
            end
            for (int i = 0; i < n; i++) begin
                grads[0] += resid[i];
                for (int k = 0; k < feats; k++) grads[k+1] += q_mul(resid[i], rows_x[i][k]);
            end
            for (int k = 0; k <= feats; k++) coefs[k] = descend(coefs[k], grads[k], n);
        end
        for (int k = 0; k <= feats; k++) begin
            e.idx  = FC_W'(k);
            e.coef = coefs[k];
            e.last = (k == feats);
            coef_q.push_back(e);
        end
        rows_held = 0;
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // Wait for the block to drain, then write all three registers
    task automatic set_config(int unsigned rate, int unsigned epochs, int unsigned feats);
        while (coef_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LEARNING_RATE;
        i_cfg_data <= rate;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_EPOCH_LIMIT;
        i_cfg_data <= epochs;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FEATURE_COUNT;
        i_cfg_data <= CFG_W'(feats & 4'hF);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sh_rate   = rate;
        sh_epochs = epochs;
        sh_feats  = feats & 4'hF;
    endtask

    // Offer one row and hold it until the transfer; drop valid after the last row
    task automatic send_row(t_row x, int y, bit last);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (rows_held < NSAMP) begin
            for (int k = 0; k < NFEAT; k++) rows_x[rows_held][k] = x[k];
            rows_y[rows_held] = y;
            rows_held++;
        end
        if (last) train_and_expect();
        i_valid       <= 1'b1;
        i_feature_0   <= x[0];
        i_feature_1   <= x[1];
        i_feature_2   <= x[2];
        i_feature_3   <= x[3];
        i_feature_4   <= x[4];
        i_feature_5   <= x[5];
        i_feature_6   <= x[6];
        i_feature_7   <= x[7];
        i_target      <= y;
        i_last_sample <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (last) i_valid <= 1'b0;
    endtask

    function automatic int rand_q();
        if ($urandom_range(0, 1)) return int'($urandom());
        return int'($urandom_range(0, 1048575)) - 524288;
    endfunction

    function automatic t_row rand_row();
        t_row r;
        for (int k = 0; k < NFEAT; k++) r[k] = rand_q();
        return r;
    endfunction

    function automatic t_row fill_row(int v);
        t_row r;
        for (int k = 0; k < NFEAT; k++) r[k] = v;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // Reset settings, full-scale features
    task automatic test_reset_settings();
        sh_rate = LR_RESET; sh_epochs = EPOCH_RESET; sh_feats = FC_RESET;
        send_row(fill_row(32'sh7FFF_FFFF), 32'sh0001_0000, 1'b0);
        send_row(fill_row(32'sh8000_0000), -32'sh0003_0000, 1'b1);
    endtask

    // Largest step, all eight features, extreme rows
    task automatic test_max_rate();
        set_config(32'hFFFF_FFFF, 3, 8);
        send_row(fill_row(32'sh7FFF_FFFF), 32'sh7FFF_FFFF, 1'b0);
        send_row(fill_row(32'sh8000_0000), 32'sh8000_0000, 1'b0);
        send_row(fill_row(0), 0, 1'b0);
        send_row(rand_row(), 32'sh0002_8000, 1'b1);
    endtask

    // Zero step and a feature count beyond the port
    task automatic test_wide_count();
        set_config(0, 2, 15);
        send_row(rand_row(), rand_q(), 1'b0);
        send_row(rand_row(), rand_q(), 1'b1);
        set_config(32'h0100_0000, 2, 9);
        send_row(rand_row(), rand_q(), 1'b1);
    endtask

    // No epochs and no features: zero bias only
    task automatic test_zero_epochs();
        set_config(32'h8000_0000, 0, 0);
        send_row(rand_row(), rand_q(), 1'b1);
    endtask

    // Largest epoch setting held briefly, then a single-row set
    task automatic test_epoch_extreme();
        set_config(32'h1000_0000, 32'hFFFF_FFFF, 3);
        set_config(32'h1000_0000, 2, 3);
        send_row(rand_row(), rand_q(), 1'b1);
    endtask

    // Random sets under each idling pattern
    task automatic test_random();
        int pct_i [4] = '{0, 63, 0, 21};
        int pct_s [4] = '{0, 0, 63, 21};
        int sent, rows, feats;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = pct_i[ph];
            stall_pct = pct_s[ph];
            sent = 0;
            while (sent < 26) begin
                feats = $urandom_range(0, 10) == 0 ? $urandom_range(9, 15) : $urandom_range(0, 8);
                set_config($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0400_0000),
                           $urandom_range(1, 5), feats);
                rows = $urandom_range(1, 8);
                for (int i = 0; i < rows; i++) send_row(rand_row(), rand_q(), i == rows - 1);
                sent += rows;
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // receiver stall, checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each coefficient transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_coef_exp e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (coef_q.size() == 0) begin
                $display("%0t: unexpected coefficient idx %0d value %0d", $time,
                         o_coef_index, o_coefficient);
                errors++;
            end else begin
                e = coef_q.pop_front();
                if (o_coef_index !== e.idx || o_coefficient !== e.coef ||
                    o_last_coef !== e.last) begin
                    $display("%0t: expected idx %0d coef %0d last %0b, got idx %0d coef %0d last %0b",
                             $time, e.idx, e.coef, e.last, o_coef_index, o_coefficient,
                             o_last_coef);
                    errors++;
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("linear_regression_gradient_descent: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        rows_held = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_settings();
        test_max_rate();
        test_wide_count();
        test_zero_epochs();
        test_epoch_extreme();
        test_random();
        while (coef_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("linear_regression_gradient_descent: match");
        end else begin
            $display("linear_regression_gradient_descent: mismatch");
        end
        $finish;
    end

endmodule

FILE: linear_regression_gradient_descent.f
hdl/lrgd_pkg.sv
hdl/lrgd_ram.sv
hdl/lrgd_div.sv
hdl/lrgd_dp.sv
hdl/lrgd_ctrl.sv
hdl/linear_regression_gradient_descent.sv
verif/linear_regression_gradient_descent_tb.sv
